FILE: rtl/core/image_flip_rotate_engine_unit_defines.svh
// Assertion macros used by the RTL of the flip and rotate engine unit.
`ifndef IMAGE_FLIP_ROTATE_ENGINE_UNIT_DEFINES_SVH
`define IMAGE_FLIP_ROTATE_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define IFRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define IFRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define IFRE_ASSERT(lbl, prop, msg)
`define IFRE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/ifre_pkg.sv
package ifre_pkg;

  typedef enum logic [2:0] {
    MODE_FLIP_H = 3'd0,
    MODE_FLIP_V = 3'd1,
    MODE_ROT90  = 3'd2,
    MODE_ROT180 = 3'd3,
    MODE_ROT270 = 3'd4,
    MODE_INVERT = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ADDR  = 2'd1,
    ST_CHECK = 2'd2,
    ST_OUT   = 2'd3
  } state_e;

  localparam logic [15:0] STAR_CODE = 16'd42;
  localparam logic [15:0] DASH_CODE = 16'd45;

  localparam logic [6:0] WIDTH_RESET  = 7'd7;
  localparam logic [6:0] HEIGHT_RESET = 7'd6;

  // Rotations by 90 and 270 degrees swap the output dimensions.
  function automatic logic is_rot(input logic [2:0] mode);
    return (mode == MODE_ROT90) || (mode == MODE_ROT270);
  endfunction

endpackage

FILE: rtl/core/image_flip_rotate_engine_unit.sv
// Load requests are accepted back to back while idle and no division is pending.
// An emit request passes the source address, the store read and the output register
// before its result is valid, and frees the input once the result is registered; one
// whose pixel is not loaded yet gives no result. A waiting result holds the next emit there.
// A write to width, height or mode holds requests off until the divider has finished.
// Reset clears counters and control and sets the registers to their reset values; the frame store is not cleared.
`include "image_flip_rotate_engine_unit_defines.svh"

module image_flip_rotate_engine_unit import ifre_pkg::*; #(
  parameter int MAX_SIDE   = 64,
  parameter int PIXEL_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_pixel
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_pixel
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;
  localparam int TOT_W  = $clog2(DEPTH + 1);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [6:0] v);
    logic [SIDE_W-1:0] r;
    if (v == 7'd0) begin
      r = SIDE_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

  // Configuration registers.
  logic [6:0]        width_q, width_d;
  logic [6:0]        height_q, height_d;
  logic [2:0]        mode_q, mode_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic              cfg_wr, geo_wr, div_start;
  reg_idx_e          cfg_idx;
  logic [SIDE_W-1:0] wc_new, hc_new, ow_new;
  logic [2*SIDE_W-1:0] total_prod;

  // Datapath state.
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] load_pos_q, load_pos_d;
  logic [ADDR_W-1:0] emit_pos_q, emit_pos_d;
  logic              full_q, full_d;
  logic [SIDE_W-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [SIDE_W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [ADDR_W-1:0] src_q, src_d;
  logic              last_q, last_d;
  logic [2*SIDE_W-1:0] src_prod;

  logic [SIDE_W-1:0] wc, hc, ow;
  logic              s_accept, load_req, emit_req, loaded, at_last, load_wrap;
  logic              mem_re, out_load;
  logic              div_busy, div_done;
  logic [ADDR_W-1:0] div_quo;
  logic [SIDE_W-1:0] div_rem;
  logic [ADDR_W-1:0] div_dividend;
  logic [PIXEL_BITS-1:0] rdata, px_out;
  logic [15:0]       inv_code;

  logic              m_valid_q, m_valid_d;
  logic [7:0]        m_data_q, m_data_d;
  logic              m_last_q, m_last_d;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    mode_d    = mode_q;
    geo_wr    = 1'b0;
    div_start = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH: begin
          width_d   = pwdata[6:0];
          geo_wr    = 1'b1;
          div_start = 1'b1;
        end
        REG_HEIGHT: begin
          height_d  = pwdata[6:0];
          geo_wr    = 1'b1;
          div_start = 1'b1;
        end
        REG_MODE: begin
          mode_d    = pwdata[2:0];
          div_start = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign wc_new     = clamp_side(width_d);
  assign hc_new     = clamp_side(height_d);
  assign ow_new     = is_rot(mode_d) ? hc_new : wc_new;
  assign total_prod = wc_new * hc_new;
  assign total_d    = geo_wr ? TOT_W'(total_prod) : total_q;

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_MODE:   prdata = 32'(mode_q);
      default:    prdata = '0;
    endcase
  end

  // The output column and row come from the emit position by division
  // whenever the output width may have changed.
  assign div_dividend = geo_wr ? '0 : emit_pos_q;

  ifre_div #(
    .DVD_W (ADDR_W),
    .DSR_W (SIDE_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (ow_new),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  assign wc = clamp_side(width_q);
  assign hc = clamp_side(height_q);
  assign ow = is_rot(mode_q) ? hc : wc;

  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign load_req  = s_accept && !s_axis_tuser;
  assign emit_req  = s_accept && s_axis_tuser;
  assign loaded    = full_q || (src_q < load_pos_q);
  assign at_last   = emit_pos_q == ADDR_W'(total_q - 1'b1);
  assign load_wrap = (TOT_W'(load_pos_q) + 1'b1) == total_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (emit_req) state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_CHECK;
      ST_CHECK: state_d = loaded ? ST_OUT : ST_IDLE;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE:  s_axis_tready = !div_busy && !div_done;
      ST_ADDR:  ;
      ST_CHECK: mem_re = loaded;
      ST_OUT:   out_load = !m_valid_q || m_axis_tready;
      default:  ;
    endcase
  end

  // Source column and row of the next output pixel.
  always_comb begin
    sx_d = ox_q;
    sy_d = oy_q;
    case (mode_q)
      MODE_FLIP_H: begin
        sx_d = wc - 1'b1 - ox_q;
      end
      MODE_FLIP_V: begin
        sy_d = hc - 1'b1 - oy_q;
      end
      MODE_ROT90: begin
        sx_d = oy_q;
        sy_d = hc - 1'b1 - ox_q;
      end
      MODE_ROT180: begin
        sx_d = wc - 1'b1 - ox_q;
        sy_d = hc - 1'b1 - oy_q;
      end
      MODE_ROT270: begin
        sx_d = wc - 1'b1 - oy_q;
        sy_d = ox_q;
      end
      default: begin
      end
    endcase
  end

  assign src_prod = sy_q * wc;
  assign src_d    = ADDR_W'(src_prod) + ADDR_W'(sx_q);
  // The last flag is taken with the store read so it holds while the result waits.
  assign last_d   = mem_re ? at_last : last_q;

  always_comb begin
    load_pos_d = load_pos_q;
    emit_pos_d = emit_pos_q;
    full_d     = full_q;
    ox_d       = ox_q;
    oy_d       = oy_q;
    if (geo_wr) begin
      load_pos_d = '0;
      emit_pos_d = '0;
      full_d     = 1'b0;
    end else begin
      if (load_req) begin
        if (load_wrap) begin
          load_pos_d = '0;
          full_d     = 1'b1;
        end else begin
          load_pos_d = load_pos_q + 1'b1;
        end
      end
      if (mem_re) begin
        if (at_last) begin
          emit_pos_d = '0;
          full_d     = 1'b0;
          ox_d       = '0;
          oy_d       = '0;
        end else begin
          emit_pos_d = emit_pos_q + 1'b1;
          if (ox_q == ow - 1'b1) begin
            ox_d = '0;
            oy_d = oy_q + 1'b1;
          end else begin
            ox_d = ox_q + 1'b1;
          end
        end
      end
    end
    if (div_done) begin
      ox_d = div_rem;
      oy_d = SIDE_W'(div_quo);
    end
  end

  // ---------------------------------------------------------------------
  // Frame store and output register
  // ---------------------------------------------------------------------
  ifre_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (PIXEL_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_req),
    .waddr_i (load_pos_q),
    .wdata_i (PIXEL_BITS'(s_axis_tdata)),
    .re_i    (mem_re),
    .raddr_i (src_q),
    .rdata_o (rdata)
  );

  assign inv_code = (16'(rdata) == STAR_CODE) ? DASH_CODE : STAR_CODE;
  assign px_out   = (mode_q == MODE_INVERT) ? PIXEL_BITS'(inv_code) : rdata;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = 8'(px_out);
      m_last_d  = last_q;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RESET;
      height_q   <= HEIGHT_RESET;
      mode_q     <= MODE_FLIP_H;
      total_q    <= TOT_W'(int'(clamp_side(WIDTH_RESET)) * int'(clamp_side(HEIGHT_RESET)));
      state_q    <= ST_IDLE;
      load_pos_q <= '0;
      emit_pos_q <= '0;
      full_q     <= 1'b0;
      ox_q       <= '0;
      oy_q       <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      mode_q     <= mode_d;
      total_q    <= total_d;
      state_q    <= state_d;
      load_pos_q <= load_pos_d;
      emit_pos_q <= emit_pos_d;
      full_q     <= full_d;
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    src_q    <= src_d;
    last_q   <= last_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `IFRE_ASSERT_ALWAYS(a_pready_high, pready, "register port not ready")
  `IFRE_ASSERT(a_pos_in_frame, (TOT_W'(load_pos_q) < total_q) && (TOT_W'(emit_pos_q) < total_q), "position")
  `IFRE_ASSERT(a_col_in_row, div_busy || div_done || (ox_q < ow), "output column beyond width")
  `IFRE_ASSERT(a_read_in_frame, mem_re |-> (TOT_W'(src_q) < total_q), "store read outside image")
  `IFRE_ASSERT(a_no_overwrite, out_load |-> (!m_valid_q || m_axis_tready), "result overwritten")

endmodule

FILE: rtl/core/ifre_store.sv
module ifre_store import ifre_pkg::*; #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read, so a stalled result stays intact.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ifre_div.sv
module ifre_div import ifre_pkg::*; #(
  parameter int DVD_W = 12,
  parameter int DSR_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o,
  output logic [DSR_W-1:0] remainder_o
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dq_q, dq_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W:0]   trial;
  logic             fits;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of dq_q while quotient bits shift in at the bottom.
  always_comb begin
    trial  = {rem_q, dq_q[DVD_W-1]};
    fits   = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = DVD_W'({dq_q, fits});
      rem_d = fits ? DSR_W'(trial - {1'b0, dsr_q}) : DSR_W'(trial);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;

endmodule
